// ===== hdl/assert_macros.svh =====
// assertion macros shared by the mapper rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed in bank mapper");

// expression that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition in bank mapper");

`endif

// ===== hdl/bmsi_pkg.sv =====
// types, decode constants and helpers for the bank mapper
// no dependencies; used by bmsi_core and bank_mapper_scanline_irq
`default_nettype none

package bmsi_pkg;

	// input item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// address decode of a cpu write
	localparam logic [15:0] DEC_MASK   = 16'hE001;
	localparam logic [15:0] DEC_MASTER = 16'h4000;
	localparam logic [15:0] DEC_LOAD   = 16'h8000;
	localparam logic [15:0] DEC_CMD    = 16'h8001;
	localparam logic [15:0] DEC_DATA   = 16'hA000;
	localparam logic [15:0] DEC_MIRROR = 16'hA001;
	localparam logic [15:0] DEC_ACK    = 16'hE000;

	// master mode fields
	localparam int unsigned MASTER_16K_BIT = 7;
	localparam logic [7:0]  MASTER_N_MASK  = 8'h1F;

	// fixed last banks in 8k mode
	localparam logic [7:0] PRG_FIXED_LO = 8'hFE;
	localparam logic [7:0] PRG_FIXED_HI = 8'hFF;

	// reset value of the program bank mask
	localparam logic [7:0] PRG_MASK_RESET = 8'hFF;

	typedef struct packed {
		logic        kind;
		logic [15:0] address;
		logic [7:0]  write_data;
	} cmd_t;

	typedef struct packed {
		logic [31:0] prg_banks;
		logic [63:0] chr_banks;
		logic        mirror_select;
		logic        irq_pending;
	} res_t;

	// internal status from the core, for checks
	typedef struct packed {
		logic irq;
		logic armed;
	} stat_t;

	function automatic logic [15:0] decode(input logic [15:0] address);
		return address & DEC_MASK;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/bmsi_core.sv =====
// mapper state and next-state logic: register decode, irq counter, bank tables
// depends on bmsi_pkg
`default_nettype none

module bmsi_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           acc,
	input  wire bmsi_pkg::cmd_t cmd,
	input  wire logic           cfg_we,
	input  wire logic [7:0]     cfg_wdata,
	output bmsi_pkg::res_t      res_nxt,
	output bmsi_pkg::stat_t     stat
);

	logic [7:0]  mask_q;
	logic [7:0]  bank_reg_q  [8];
	logic [7:0]  bank_reg_n  [8];
	logic [7:0]  chr_q       [8];
	logic [7:0]  chr_n       [8];
	logic [7:0]  master_q, master_n;
	logic [7:0]  bank_cmd_q, bank_cmd_n;
	logic        armed_q, armed_n;
	logic [7:0]  line_q, line_n;
	logic        irq_q, irq_n;
	logic        mirror_q, mirror_n;
	logic        recompute;
	logic [15:0] dec;
	logic [6:0]  pair0, pair7;
	logic [4:0]  n16;
	logic [7:0]  slot [4];

	// next state for one transfer
	always_comb begin
		dec        = bmsi_pkg::decode(cmd.address);
		bank_reg_n = bank_reg_q;
		master_n   = master_q;
		bank_cmd_n = bank_cmd_q;
		armed_n    = armed_q;
		line_n     = line_q;
		irq_n      = irq_q;
		mirror_n   = mirror_q;
		recompute  = 1'b0;
		if (cmd.kind == bmsi_pkg::KIND_WRITE) begin
			unique case (dec)
				bmsi_pkg::DEC_MASTER: master_n = cmd.write_data;
				bmsi_pkg::DEC_LOAD:   line_n = cmd.write_data;
				bmsi_pkg::DEC_ACK:    irq_n = 1'b0;
				bmsi_pkg::DEC_MIRROR: mirror_n = ~cmd.write_data[0];
				bmsi_pkg::DEC_CMD: begin
					bank_cmd_n = cmd.write_data;
					armed_n    = 1'b1;
					recompute  = 1'b1;
				end
				bmsi_pkg::DEC_DATA: begin
					if (armed_q) begin
						bank_reg_n[bank_cmd_q[2:0]] = cmd.write_data;
						armed_n   = 1'b0;
						recompute = 1'b1;
					end
				end
				default: ;
			endcase
		end else if (line_q != 8'd0) begin
			// scanline tick counts down and fires at zero
			line_n = line_q - 8'd1;
			if (line_n == 8'd0) begin
				irq_n = 1'b1;
			end
		end
	end

	// character page recompute from the updated command and registers
	always_comb begin
		chr_n = chr_q;
		pair0 = bank_reg_n[0][7:1];
		pair7 = bank_reg_n[7][7:1];
		if (recompute) begin
			if (!bank_cmd_n[7]) begin
				chr_n[0] = {pair0, 1'b0};
				chr_n[1] = {pair0, 1'b1};
				chr_n[2] = {pair7, 1'b0};
				chr_n[3] = {pair7, 1'b1};
			end
			chr_n[4] = {1'b0, bank_reg_n[5][7:1]};
			chr_n[5] = {1'b0, bank_reg_n[2][7:1]};
			chr_n[6] = {1'b0, bank_reg_n[6][7:1]};
			chr_n[7] = {1'b0, bank_reg_n[4][7:1]};
		end
	end

	// program bank slots, masked
	always_comb begin
		n16 = master_n[4:0] & bmsi_pkg::MASTER_N_MASK[4:0];
		if (master_n[bmsi_pkg::MASTER_16K_BIT]) begin
			slot[0] = {2'b00, n16, 1'b0};
			slot[1] = {2'b00, n16, 1'b1};
			slot[2] = {2'b00, n16, 1'b0};
			slot[3] = {2'b00, n16, 1'b1};
		end else begin
			slot[0] = bank_reg_n[1];
			slot[1] = bank_reg_n[3];
			slot[2] = bmsi_pkg::PRG_FIXED_LO;
			slot[3] = bmsi_pkg::PRG_FIXED_HI;
		end
		res_nxt.prg_banks = {slot[3] & mask_q, slot[2] & mask_q,
			slot[1] & mask_q, slot[0] & mask_q};
		res_nxt.chr_banks = {chr_n[7], chr_n[6], chr_n[5], chr_n[4],
			chr_n[3], chr_n[2], chr_n[1], chr_n[0]};
		res_nxt.mirror_select = mirror_n;
		res_nxt.irq_pending   = irq_n;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= bmsi_pkg::PRG_MASK_RESET;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	// mapper state, updated on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_reg_q <= '{default: 8'd0};
			// power-on character pages 0,1,0,1 then zero
			chr_q      <= '{8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0};
			master_q   <= 8'd0;
			bank_cmd_q <= 8'd0;
			armed_q    <= 1'b0;
			line_q     <= 8'd0;
			irq_q      <= 1'b0;
			mirror_q   <= 1'b0;
		end else if (acc) begin
			bank_reg_q <= bank_reg_n;
			chr_q      <= chr_n;
			master_q   <= master_n;
			bank_cmd_q <= bank_cmd_n;
			armed_q    <= armed_n;
			line_q     <= line_n;
			irq_q      <= irq_n;
			mirror_q   <= mirror_n;
		end
	end

	assign stat.irq   = irq_q;
	assign stat.armed = armed_q;

endmodule

`default_nettype wire

// ===== hdl/bank_mapper_scanline_irq.sv =====
// top level of the bank mapper with scanline interrupt: handshake and result register
// depends on bmsi_pkg, bmsi_core and assert_macros.svh
//
//  channel | signals                   | direction | content
//  cmd     | cmd_valid cmd_ready cmd   | in        | cpu write or scanline tick
//  res     | res_valid res_ready res   | out       | banks, mirroring, irq line
//  cfg     | cfg_we cfg_wdata          | in        | program bank mask
//
// one item per cycle when not stalled; its result is valid the cycle after the transfer
// state and result register update in the same edge, the core logic is one level deep
// cmd_ready is high whenever the result register is empty or being taken
// a stalled result holds while further items wait; reset empties the result register
// reset is asynchronous, active low, and loads the power-on bank tables
`default_nettype none
`include "assert_macros.svh"

module bank_mapper_scanline_irq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire bmsi_pkg::cmd_t cmd,
	output logic                res_valid,
	input  wire logic           res_ready,
	output bmsi_pkg::res_t      res,
	input  wire logic           cfg_we,
	input  wire logic [7:0]     cfg_wdata
);

	logic            acc;
	logic            res_valid_q;
	bmsi_pkg::res_t  res_q;
	bmsi_pkg::res_t  res_nxt;
	bmsi_pkg::stat_t stat;

	// accept when the result slot is free this cycle
	assign cmd_ready = !res_valid_q || res_ready;
	assign acc       = cmd_valid && cmd_ready;

	bmsi_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_nxt   (res_nxt),
		.stat      (stat)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// every transfer yields a result next cycle
	`ASSERT_CLK(a_acc_gives_res, clk, arst_n, acc |=> res_valid_q)
	// irq only rises on a scanline tick
	`ASSERT_CLK(a_irq_from_tick, clk, arst_n,
		$rose(stat.irq) |-> $past(acc && cmd.kind == bmsi_pkg::KIND_TICK))
	// arm clears only through a bank data write
	`ASSERT_CLK(a_disarm_by_data, clk, arst_n,
		$fell(stat.armed) |-> $past(acc && cmd.kind == bmsi_pkg::KIND_WRITE
		&& bmsi_pkg::decode(cmd.address) == bmsi_pkg::DEC_DATA))
	// the reported irq line follows the core state after each transfer
	`ASSERT_CLK(a_irq_matches, clk, arst_n,
		$past(acc) |-> res_q.irq_pending == stat.irq)

endmodule

`default_nettype wire

// ===== tb/sv/bank_mapper_scanline_irq_test.sv =====
`timescale 1ns / 1ps
// testbench for the bank mapper with scanline interrupt: directed and random cpu writes and ticks
// results are predicted by a scoreboard class; depends on bmsi_pkg and bank_mapper_scanline_irq

// mapper state model and store of expected bank results
class mapper_scoreboard;
	logic [7:0] prg_mask;
	logic [7:0] bank_reg [8];
	logic [7:0] master_mode;
	logic [7:0] bank_command;
	logic       armed;
	logic [7:0] line_count;
	logic       irq;
	logic       mirror;
	logic [7:0] chr_page [8];
	bmsi_pkg::res_t expected_q [$];
	int errors;

	// power-on state
	function new();
		prg_mask = bmsi_pkg::PRG_MASK_RESET;
		for (int i = 0; i < 8; i++) begin
			bank_reg[i] = 8'd0;
			chr_page[i] = 8'd0;
		end
		chr_page[1] = 8'd1;
		chr_page[3] = 8'd1;
		master_mode = 8'd0;
		bank_command = 8'd0;
		armed = 1'b0;
		line_count = 8'd0;
		irq = 1'b0;
		mirror = 1'b0;
		errors = 0;
	endfunction

	function void set_mask(input logic [7:0] m);
		prg_mask = m;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// two consecutive 1k pages from one 2k register
	function void set_chr_pair(input int page, input logic [7:0] r);
		chr_page[page % 8] = {r[7:1], 1'b0};
		chr_page[(page + 1) % 8] = {r[7:1], 1'b1};
	endfunction

	// character pages after a command or an accepted data write
	function void refresh_chr();
		int b;
		b = bank_command[7] ? 4 : 0;
		set_chr_pair(b, bank_reg[0]);
		set_chr_pair(b + 2, bank_reg[7]);
		chr_page[4] = bank_reg[5] >> 1;
		chr_page[5] = bank_reg[2] >> 1;
		chr_page[6] = bank_reg[6] >> 1;
		chr_page[7] = bank_reg[4] >> 1;
	endfunction

	// apply one accepted transfer and queue the result it causes
	function void note_item(input bmsi_pkg::cmd_t c);
		logic [7:0] slot [4];
		logic [7:0] n2;
		bmsi_pkg::res_t e;
		if (c.kind == bmsi_pkg::KIND_WRITE) begin
			case (c.address & bmsi_pkg::DEC_MASK)
				bmsi_pkg::DEC_MASTER: master_mode = c.write_data;
				bmsi_pkg::DEC_LOAD:   line_count = c.write_data;
				bmsi_pkg::DEC_ACK:    irq = 1'b0;
				bmsi_pkg::DEC_MIRROR: mirror = ~c.write_data[0];
				bmsi_pkg::DEC_CMD: begin
					bank_command = c.write_data;
					armed = 1'b1;
					refresh_chr();
				end
				bmsi_pkg::DEC_DATA: begin
					// data is taken once per command
					if (armed) begin
						bank_reg[bank_command[2:0]] = c.write_data;
						refresh_chr();
						armed = 1'b0;
					end
				end
				default: ;
			endcase
		end else if (line_count != 8'd0) begin
			line_count = line_count - 8'd1;
			if (line_count == 8'd0)
				irq = 1'b1;
		end
		// program slots, 16k or 8k mode
		if (master_mode[bmsi_pkg::MASTER_16K_BIT]) begin
			n2 = (master_mode & bmsi_pkg::MASTER_N_MASK) << 1;
			slot[0] = n2;
			slot[1] = n2 | 8'd1;
			slot[2] = n2;
			slot[3] = n2 | 8'd1;
		end else begin
			slot[0] = bank_reg[1];
			slot[1] = bank_reg[3];
			slot[2] = bmsi_pkg::PRG_FIXED_LO;
			slot[3] = bmsi_pkg::PRG_FIXED_HI;
		end
		e.prg_banks = {slot[3] & prg_mask, slot[2] & prg_mask,
			slot[1] & prg_mask, slot[0] & prg_mask};
		e.chr_banks = {chr_page[7], chr_page[6], chr_page[5], chr_page[4],
			chr_page[3], chr_page[2], chr_page[1], chr_page[0]};
		e.mirror_select = mirror;
		e.irq_pending = irq;
		expected_q.push_back(e);
	endfunction

	// compare one result transfer with the oldest expectation
	function void check_result(input bmsi_pkg::res_t r);
		bmsi_pkg::res_t e;
		if (expected_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("result %h arrived with nothing pending", r);
			return;
		end
		e = expected_q.pop_front();
		if (r.prg_banks !== e.prg_banks || r.chr_banks !== e.chr_banks ||
				r.mirror_select !== e.mirror_select || r.irq_pending !== e.irq_pending) begin
			errors++;
			if (errors <= 10)
				$display("mismatch exp/act: prg %h/%h chr %h/%h mirror %b/%b irq %b/%b",
					e.prg_banks, r.prg_banks, e.chr_banks, r.chr_banks,
					e.mirror_select, r.mirror_select, e.irq_pending, r.irq_pending);
		end
	endfunction
endclass

module bank_mapper_scanline_irq_test;

	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 260;
	localparam int PHASES      = 6;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cmd_valid = 1'b0;
	logic           cmd_ready;
	bmsi_pkg::cmd_t cmd = '0;
	logic           res_valid;
	logic           res_ready = 1'b0;
	bmsi_pkg::res_t res;
	logic           cfg_we = 1'b0;
	logic [7:0]     cfg_wdata = 8'd0;

	mapper_scoreboard board;
	bit hold_req = 1'b0;
	int burst_left = 0;
	int idle_cycles = 0;
	int sent = 0;

	bank_mapper_scanline_irq dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// result side stall pattern, with one long hold-off on request
	initial begin
		int mode;
		int cyc;
		mode = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				cyc++;
				if (cyc % 64 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: res_ready <= 1'b1;
					1: res_ready <= 1'($urandom_range(0, 1));
					2: res_ready <= (cyc % 3 == 0);
					default: res_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// check every result transfer
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			board.check_result(res);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("no transfer for %0d cycles", IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic bmsi_pkg::cmd_t write_at(input logic [15:0] a, input logic [7:0] d);
		bmsi_pkg::cmd_t c;
		c.kind = bmsi_pkg::KIND_WRITE;
		c.address = a;
		c.write_data = d;
		return c;
	endfunction

	// write with the given decode and random don't-care address bits
	function automatic bmsi_pkg::cmd_t decoded(input logic [15:0] dec, input logic [7:0] d);
		return write_at(dec | (16'($urandom) & ~bmsi_pkg::DEC_MASK), d);
	endfunction

	function automatic bmsi_pkg::cmd_t tick_item();
		bmsi_pkg::cmd_t c;
		c.kind = bmsi_pkg::KIND_TICK;
		c.address = 16'($urandom);
		c.write_data = 8'($urandom);
		return c;
	endfunction

	// offer one item and hold it until its transfer
	task automatic send_item(input bmsi_pkg::cmd_t c);
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		board.note_item(c);
		sent++;
	endtask

	// bursts of random length with random gaps between them
	task automatic send_paced(input bmsi_pkg::cmd_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send_paced_done: send_item(c);
	endtask

	// mask write while the block is idle
	task automatic set_prg_mask(input logic [7:0] m);
		cmd_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_mask(m);
	endtask

	// extremes, every decode and the corner cases of arming and counting
	task automatic run_directed();
		send_paced(tick_item());                 // tick with zero counter after reset
		send_paced(write_at(16'hA000, 8'h77));   // data write with no command armed
		send_paced(write_at(16'h8001, 8'h00));
		send_paced(write_at(16'hBFFE, 8'hFF));
		send_paced(write_at(16'hA000, 8'h55));   // second data write is ignored
		send_paced(write_at(16'h9FFF, 8'h87));   // upper character layout, register 7
		send_paced(write_at(16'hA000, 8'hFE));
		send_paced(write_at(16'h8001, 8'h01));
		send_paced(write_at(16'hA000, 8'h3C));
		send_paced(write_at(16'h8001, 8'h03));
		send_paced(write_at(16'hA000, 8'hC3));
		send_paced(write_at(16'h5FFE, 8'h9F));   // 16k mode, largest bank pair
		send_paced(write_at(16'h4000, 8'h00));
		send_paced(write_at(16'hBFFF, 8'h00));
		send_paced(write_at(16'hA001, 8'hFF));
		send_paced(write_at(16'h8000, 8'h00));   // load of zero disables the count
		send_paced(tick_item());
		send_paced(write_at(16'h8000, 8'h02));
		send_paced(tick_item());
		send_paced(tick_item());                 // reaches zero, irq rises
		send_paced(tick_item());
		send_paced(write_at(16'hFFFE, 8'hFF));   // irq acknowledge
		send_paced(write_at(16'hC000, 8'hFF));   // unused decodes
		send_paced(write_at(16'hDFFF, 8'hFF));
		send_paced(write_at(16'hFFFF, 8'hFF));
		send_paced(write_at(16'h0000, 8'hFF));
	endtask

	// one random sequence, mostly well-formed
	task automatic send_random_group();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			// command followed by its data
			send_paced(decoded(bmsi_pkg::DEC_CMD, 8'($urandom)));
			send_paced(decoded(bmsi_pkg::DEC_DATA, 8'($urandom)));
		end else if (pick < 50) begin
			// counter load, a run of ticks, maybe an acknowledge
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
			send_paced(decoded(bmsi_pkg::DEC_LOAD, 8'(n)));
			repeat ($urandom_range(1, 8)) send_paced(tick_item());
			if ($urandom_range(0, 1) == 1)
				send_paced(decoded(bmsi_pkg::DEC_ACK, 8'($urandom)));
		end else if (pick < 58) begin
			send_paced(decoded(bmsi_pkg::DEC_MASTER, 8'($urandom)));
		end else if (pick < 64) begin
			send_paced(decoded(bmsi_pkg::DEC_MIRROR, 8'($urandom)));
		end else if (pick < 70) begin
			send_paced(decoded(bmsi_pkg::DEC_ACK, 8'($urandom)));
		end else if (pick < 80) begin
			send_paced(tick_item());
		end else if (pick < 90) begin
			send_paced(25'($urandom));
		end else begin
			// broken sequences: stray data, double command, double data
			if ($urandom_range(0, 1) == 1)
				send_paced(decoded(bmsi_pkg::DEC_CMD, 8'($urandom)));
			send_paced(decoded(bmsi_pkg::DEC_CMD, 8'($urandom)));
			send_paced(decoded(bmsi_pkg::DEC_DATA, 8'($urandom)));
			send_paced(decoded(bmsi_pkg::DEC_DATA, 8'($urandom)));
		end
	endtask

	task automatic run_random(input int count, input bit with_hold);
		int start;
		bit held;
		start = sent;
		held = 1'b0;
		while (sent - start < count) begin
			if (with_hold && !held && sent - start >= count / 2) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			send_random_group();
		end
	endtask

	// main sequence: reset, then phases at several mask settings
	initial begin
		logic [7:0] masks [PHASES];
		masks[0] = bmsi_pkg::PRG_MASK_RESET;
		masks[1] = 8'h00;
		masks[2] = 8'h0F;
		masks[3] = 8'h3F;
		masks[4] = 8'($urandom);
		masks[5] = 8'hFF;
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < PHASES; i++) begin
			set_prg_mask(masks[i]);
			if (i == 0)
				run_directed();
			run_random(PHASE_ITEMS, i == 2);
		end
		cmd_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== bank_mapper_scanline_irq.f =====
+incdir+hdl
hdl/bmsi_pkg.sv
hdl/bmsi_core.sv
hdl/bank_mapper_scanline_irq.sv
tb/sv/bank_mapper_scanline_irq_test.sv
